// ===== hdl/double_ended_queue_top_defines.svh =====
// Assertion macros for the double-ended queue
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define DQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/dq_pkg.sv =====
package dq_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int OUT_CNT_W = 11;

    localparam logic [DATA_W-1:0] NONE_VALUE = '1;

    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic                     pop_was_empty;
        logic                     push_dropped;
        logic [OUT_CNT_W-1:0]     entry_count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } dq_result_t;

endpackage

// ===== hdl/dq_ram.sv =====
module dq_ram #(
    parameter int DEPTH_P = 1024,
    parameter int WIDTH_P = 32,
    parameter int ADDR_P  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_P-1:0]  wr_addr,
    input  logic [WIDTH_P-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_P-1:0]  rd_addr,
    output logic [WIDTH_P-1:0] rd_data
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/dq_core.sv =====
module dq_core
    import dq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic signed [DATA_W-1:0] s_push_value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output dq_result_t               res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] front_reg, front_next;
    logic [DATA_W-1:0] back_reg, back_next;
    logic [DATA_W-1:0] popped_reg, popped_next;
    logic              was_empty_reg, was_empty_next;
    logic              dropped_reg, dropped_next;
    logic              side_front_reg, side_front_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              accept;
    logic              full;
    logic              empty;

    function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] a);
        return (a == ADDR_W'(DEPTH - 1)) ? '0 : a + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] a);
        return (a == '0) ? ADDR_W'(DEPTH - 1) : a - ADDR_W'(1);
    endfunction

    dq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_W),
        .ADDR_P  (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // Decode the command, move the pointers and refresh the end caches
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        popped_next     = popped_reg;
        was_empty_next  = was_empty_reg;
        dropped_next    = dropped_reg;
        side_front_next = side_front_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    popped_next    = NONE_VALUE;
                    was_empty_next = 1'b0;
                    dropped_next   = 1'b0;
                    state_next     = ST_WAIT;
                    case (s_cmd)
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                dropped_next = 1'b1;
                            end else begin
                                head_next  = slot_dec(head_reg);
                                wr_en      = 1'b1;
                                wr_addr    = head_next;
                                front_next = s_push_value;
                                if (empty) begin
                                    back_next = s_push_value;
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                dropped_next = 1'b1;
                            end else begin
                                tail_next = slot_inc(tail_reg);
                                wr_en     = 1'b1;
                                wr_addr   = tail_next;
                                back_next = s_push_value;
                                if (empty) begin
                                    front_next = s_push_value;
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                was_empty_next = 1'b1;
                            end else begin
                                popped_next = front_reg;
                                head_next   = slot_inc(head_reg);
                                count_next  = count_reg - CNT_W'(1);
                                if (count_reg > CNT_W'(1)) begin
                                    rd_en           = 1'b1;
                                    rd_addr         = head_next;
                                    side_front_next = 1'b1;
                                    state_next      = ST_READ;
                                end
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                was_empty_next = 1'b1;
                            end else begin
                                popped_next = back_reg;
                                tail_next   = slot_dec(tail_reg);
                                count_next  = count_reg - CNT_W'(1);
                                if (count_reg > CNT_W'(1)) begin
                                    rd_en           = 1'b1;
                                    rd_addr         = tail_next;
                                    side_front_next = 1'b0;
                                    state_next      = ST_READ;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // Refill the end that the pop exposed
                if (side_front_reg) begin
                    front_next = rd_data;
                end else begin
                    back_next = rd_data;
                end
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= ADDR_W'(DEPTH - 1);
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Payload state
    always_ff @(posedge aclk) begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        popped_reg     <= popped_next;
        was_empty_reg  <= was_empty_next;
        dropped_reg    <= dropped_next;
        side_front_reg <= side_front_next;
    end

    // Present the result once both ends are settled
    assign res_valid         = (state_reg == ST_WAIT);
    assign res.popped_value  = popped_reg;
    assign res.pop_was_empty = was_empty_reg;
    assign res.push_dropped  = dropped_reg;
    assign res.entry_count   = OUT_CNT_W'(count_reg);
    assign res.is_empty      = empty;
    assign res.front_value   = empty ? NONE_VALUE : front_reg;
    assign res.back_value    = empty ? NONE_VALUE : back_reg;

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// Double-ended queue of signed 32-bit words, up to DEPTH entries.
// Input channel s_*: one command per transfer (query, push front, push back,
// pop front, pop back) with the value to push.
// Result channel m_*: one result per command, giving the popped value and
// flags, then the count, empty flag and both end values after the command.
// A result passes the core's wait state and then the output register; a pop
// that leaves the deque non-empty first passes a read state, since the newly
// exposed end is read from the entry memory (one write port, one read port,
// registered read). The command sequencer works on one command at a time and
// takes no new command until the last result has been handed to the output register.
// The result sits in an output register; the next command is taken while it
// waits, and a further one only after that result moves into the register.
// When the receiver stalls, m_valid and the payload hold until transfer.
// Reset clears the pointers and the count, so the deque starts empty; the
// entry memory needs no clearing, as only held entries are ever read.
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top
    import dq_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [CMD_W-1:0]            s_cmd,
    input  logic signed [DATA_W-1:0]    s_push_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DATA_W-1:0]    m_popped_value,
    output logic                        m_pop_was_empty,
    output logic                        m_push_dropped,
    output logic [OUT_CNT_W-1:0]        m_entry_count,
    output logic                        m_is_empty,
    output logic signed [DATA_W-1:0]    m_front_value,
    output logic signed [DATA_W-1:0]    m_back_value
);

    dq_result_t res;
    dq_result_t out_reg;
    logic       res_valid;
    logic       res_ready;
    logic       m_valid_reg;
    logic       load;

    dq_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_push_value (s_push_value),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // Take a new result when the output register is empty or draining
    assign res_ready = !m_valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    // Hold the payload until transfer
    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_popped_value  = out_reg.popped_value;
    assign m_pop_was_empty = out_reg.pop_was_empty;
    assign m_push_dropped  = out_reg.push_dropped;
    assign m_entry_count   = out_reg.entry_count;
    assign m_is_empty      = out_reg.is_empty;
    assign m_front_value   = out_reg.front_value;
    assign m_back_value    = out_reg.back_value;

    `DQ_ASSERT(a_empty_matches_count, m_valid |-> (m_is_empty == (m_entry_count == '0)), "empty flag disagrees with count")
    `DQ_ASSERT(a_empty_ends_none, (m_valid && m_is_empty) |-> ((m_front_value == -1) && (m_back_value == -1)), "empty deque shows end values")
    `DQ_ASSERT(a_failed_pop_none, (m_valid && m_pop_was_empty) |-> ((m_popped_value == -1) && !m_push_dropped), "failed pop returned a value")
    `DQ_ASSERT(a_count_in_range, m_valid |-> (m_entry_count <= OUT_CNT_W'(DEPTH)), "count beyond depth")
    `DQ_ASSERT_ALWAYS(a_reset_clears_valid, !$past(aresetn) |-> !m_valid, "result valid straight after reset")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import dq_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int REPORT_MAX  = 10;

    // Command codes outside the defined set; the block treats them as a query
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    // Tracks the deque contents and the results still owed by the block
    class deque_tracker;
        logic signed [DATA_W-1:0] slot_word [DEPTH];
        int                       front_slot;
        int                       entry_total;
        dq_result_t               pending_results [$];
        int                       fault_count;

        function new();
            front_slot  = 0;
            entry_total = 0;
            fault_count = 0;
        endfunction

        function int back_slot();
            return (front_slot + entry_total - 1) % DEPTH;
        endfunction

        // Apply one accepted command and queue the result it must produce
        function void apply_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] word);
            dq_result_t r;
            r.popped_value  = NONE_VALUE;
            r.pop_was_empty = 1'b0;
            r.push_dropped  = 1'b0;
            case (cmd)
                CMD_PUSH_FRONT: begin
                    if (entry_total == DEPTH) begin
                        r.push_dropped = 1'b1;
                    end else begin
                        front_slot = (front_slot + DEPTH - 1) % DEPTH;
                        slot_word[front_slot] = word;
                        entry_total++;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (entry_total == DEPTH) begin
                        r.push_dropped = 1'b1;
                    end else begin
                        slot_word[(front_slot + entry_total) % DEPTH] = word;
                        entry_total++;
                    end
                end
                CMD_POP_FRONT: begin
                    if (entry_total == 0) begin
                        r.pop_was_empty = 1'b1;
                    end else begin
                        r.popped_value = slot_word[front_slot];
                        front_slot = (front_slot + 1) % DEPTH;
                        entry_total--;
                    end
                end
                CMD_POP_BACK: begin
                    if (entry_total == 0) begin
                        r.pop_was_empty = 1'b1;
                    end else begin
                        r.popped_value = slot_word[back_slot()];
                        entry_total--;
                    end
                end
                default: begin
                end
            endcase
            r.entry_count = OUT_CNT_W'(entry_total);
            r.is_empty    = (entry_total == 0);
            r.front_value = (entry_total == 0) ? NONE_VALUE : slot_word[front_slot];
            r.back_value  = (entry_total == 0) ? NONE_VALUE : slot_word[back_slot()];
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Compare one result transfer against the oldest owed result
        function void compare_result(dq_result_t got);
            dq_result_t want;
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("%0t: result transfer with nothing owed", $realtime);
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (got.popped_value !== want.popped_value || got.pop_was_empty !== want.pop_was_empty
                || got.push_dropped !== want.push_dropped || got.entry_count !== want.entry_count
                || got.is_empty !== want.is_empty || got.front_value !== want.front_value
                || got.back_value !== want.back_value) begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("%0t: mismatch exp pop=%0d empt=%0b drop=%0b cnt=%0d e=%0b f=%0d b=%0d",
                             $realtime, want.popped_value, want.pop_was_empty, want.push_dropped,
                             want.entry_count, want.is_empty, want.front_value, want.back_value,
                             "\n    got pop=%0d empt=%0b drop=%0b cnt=%0d e=%0b f=%0d b=%0d",
                             got.popped_value, got.pop_was_empty, got.push_dropped,
                             got.entry_count, got.is_empty, got.front_value, got.back_value);
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd;
    logic signed [DATA_W-1:0] s_push_value;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_popped_value;
    logic                     m_pop_was_empty;
    logic                     m_push_dropped;
    logic [OUT_CNT_W-1:0]     m_entry_count;
    logic                     m_is_empty;
    logic signed [DATA_W-1:0] m_front_value;
    logic signed [DATA_W-1:0] m_back_value;

    deque_tracker tracker = new();
    int           cycle_count;
    int           burst_left;
    int           ready_mode;
    int           mode_left;
    int           stall_tick;
    int           run_left;
    logic         run_high;

    double_ended_queue_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_push_value    (s_push_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_popped_value  (m_popped_value),
        .m_pop_was_empty (m_pop_was_empty),
        .m_push_dropped  (m_push_dropped),
        .m_entry_count   (m_entry_count),
        .m_is_empty      (m_is_empty),
        .m_front_value   (m_front_value),
        .m_back_value    (m_back_value)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: switch between always ready, random stalls, a fixed cycle and long runs
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        stall_tick++;
        if (run_left == 0) begin
            run_high = !run_high;
            run_left = run_high ? $urandom_range(1, 10) : $urandom_range(1, 15);
        end else begin
            run_left--;
        end
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ((stall_tick % 6) < 4);
            default: m_ready <= run_high;
        endcase
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.compare_result('{m_popped_value, m_pop_was_empty, m_push_dropped,
                                     m_entry_count, m_is_empty, m_front_value, m_back_value});
    end

    function automatic logic signed [DATA_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return NONE_VALUE;
            default: return $urandom;
        endcase
    endfunction

    // Weighted command choice; the remainder spans every code, spare ones included
    function automatic logic [CMD_W-1:0] pick_command(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        return CMD_W'($urandom_range(0, 7));
    endfunction

    // Drive one command in sender bursts and hold it until the transfer
    task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_push_value <= word;
        do
            @(posedge aclk);
        while (!s_ready);
        tracker.apply_command(cmd, word);
    endtask

    // Hold the sender off until every owed result has arrived
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_random(int count, int push_pct, int pop_pct);
        repeat (count) send_command(pick_command(push_pct, pop_pct), random_word());
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_cmd        = CMD_QUERY;
        s_push_value = '0;
        m_ready      = 1'b0;
        cycle_count  = 0;
        burst_left   = 0;
        ready_mode   = 0;
        mode_left    = 0;
        stall_tick   = 0;
        run_left     = 0;
        run_high     = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty deque: queries, pops and spare codes
        send_command(CMD_QUERY, WORD_MAX);
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_POP_BACK, WORD_MIN);
        send_command(CMD_SPARE_A, NONE_VALUE);
        send_command(CMD_SPARE_B, WORD_MAX);
        send_command(CMD_SPARE_C, WORD_MIN);
        // Extreme values at both ends, then take them out again
        send_command(CMD_PUSH_BACK, WORD_MAX);
        send_command(CMD_PUSH_FRONT, WORD_MIN);
        send_command(CMD_QUERY, '0);
        send_command(CMD_PUSH_BACK, '0);
        send_command(CMD_PUSH_FRONT, NONE_VALUE);
        send_command(CMD_SPARE_B, 32'sh1234_5678);
        send_command(CMD_POP_BACK, WORD_MAX);
        send_command(CMD_POP_FRONT, WORD_MIN);
        send_command(CMD_POP_FRONT, '0);
        send_command(CMD_POP_BACK, NONE_VALUE);
        send_command(CMD_POP_BACK, '0);
        // Single entry seen from both ends
        send_command(CMD_PUSH_FRONT, 32'sh5A5A_A5A5);
        send_command(CMD_QUERY, NONE_VALUE);
        send_command(CMD_POP_FRONT, WORD_MAX);
        send_command(CMD_PUSH_BACK, -32'sd2);
        send_command(CMD_POP_BACK, WORD_MIN);
        wait_drained();

        // Balanced traffic near empty
        send_random(250, 25, 25);
        wait_drained();

        // Grow the deque well away from empty, wrapping the pointers
        send_random(200, 70, 15);

        // Drain to empty, then work the empty boundary
        while (tracker.entry_total > 0)
            send_command(pick_command(5, 90), random_word());
        send_random(40, 20, 50);
        wait_drained();

        send_random(100, 35, 30);

        // Let the last results arrive, then allow for the block's latency
        wait_drained();
        repeat (10) @(posedge aclk);
        if (tracker.fault_count == 0 && tracker.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/dq_core.sv
hdl/double_ended_queue_top.sv
tb/sv/tb.sv
